/* rtl/mmp_pkg.sv */
// shared constants, types and control codes of the 2^251-9 modular multiplier
package mmp_pkg;

   localparam int NUM_LIMBS   = 10;
   localparam int LIMB_BITS   = 26;
   localparam int TOP_BITS    = 17;
   localparam int PROD_LIMBS  = 2 * NUM_LIMBS;
   localparam int FOLD_ROUNDS = 3;
   localparam int ACC_BITS    = 56;
   localparam int CARRY_BITS  = 31;
   localparam int STEP_BITS   = 5;
   localparam int CNT_BITS    = 4;
   localparam int RND_BITS    = 2;

   localparam logic [LIMB_BITS-1:0] TOP_MASK = 26'h001FFFF;
   localparam logic [4:0] FOLD_MUL = 5'd9;

   typedef logic [LIMB_BITS-1:0]  limb_type;
   typedef logic [ACC_BITS-1:0]   acc_type;
   typedef logic [CARRY_BITS-1:0] carry_type;
   typedef logic [STEP_BITS-1:0]  step_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MUL,
      ST_FOLD,
      ST_FINAL,
      ST_RES
   } state_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_MUL_EMIT,
      OP_FOLD,
      OP_FINAL,
      OP_RES_LOAD
   } op_type;

   // control from the sequencer to the reduction chain
   typedef struct packed {
      op_type   op;
      step_type step;
      logic     first;
      logic     res_shift;
   } ctrl_type;

endpackage

/* rtl/mmp_mac_cell.sv */
// one multiply-accumulate cell of the product row: holds one b limb and a column sum
module mmp_mac_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              b_wr,
   input  logic              b_clr,
   input  mmp_pkg::limb_type b_val,
   input  mmp_pkg::limb_type a_val,
   input  mmp_pkg::acc_type  acc_right,
   output mmp_pkg::acc_type  acc
);

   mmp_pkg::limb_type b_ff, b_in;
   mmp_pkg::acc_type  acc_ff, acc_in;
   logic [2*mmp_pkg::LIMB_BITS-1:0] prod;

   // held b limb, cleared after each operation
   always_comb begin
      b_in = b_ff;
      if (b_clr) begin
         b_in = '0;
      end else if (b_wr) begin
         b_in = b_val;
      end
   end

   // partial product added to the sum handed over by the right neighbor
   assign prod = a_val * b_ff;

   always_comb begin
      acc_in = acc_ff;
      if (en) begin
         acc_in = acc_right + {{(mmp_pkg::ACC_BITS-2*mmp_pkg::LIMB_BITS){1'b0}}, prod};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff   <= '0;
         acc_ff <= '0;
      end else begin
         b_ff   <= b_in;
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

/* rtl/mmp_reduce.sv */
// product limb chain with serial carry, fold by 9, final subtract and residue chain
module mmp_reduce (
   input  logic               clock,
   input  logic               reset,
   input  mmp_pkg::ctrl_type  ctrl,
   input  mmp_pkg::acc_type   col_in,
   output mmp_pkg::limb_type  res_head
);

   mmp_pkg::limb_type  prod_ff [mmp_pkg::PROD_LIMBS];
   mmp_pkg::limb_type  prod_in [mmp_pkg::PROD_LIMBS];
   mmp_pkg::limb_type  w_ff    [mmp_pkg::NUM_LIMBS];
   mmp_pkg::limb_type  w_in    [mmp_pkg::NUM_LIMBS];
   mmp_pkg::limb_type  res_ff  [mmp_pkg::NUM_LIMBS];
   mmp_pkg::limb_type  res_in  [mmp_pkg::NUM_LIMBS];
   mmp_pkg::carry_type carry_ff, carry_in, carry_src;

   mmp_pkg::limb_type head, low, hi, tail;
   logic [mmp_pkg::ACC_BITS:0] msum;
   logic [31:0] fsum;
   logic [mmp_pkg::LIMB_BITS:0] ssum;
   logic sel_w;

   assign head = prod_ff[0];

   // carry starts at zero, or at nine for the final subtract
   always_comb begin
      carry_src = carry_ff;
      if (ctrl.first) begin
         carry_src = (ctrl.op == mmp_pkg::OP_FINAL)
                   ? {{(mmp_pkg::CARRY_BITS-5){1'b0}}, mmp_pkg::FOLD_MUL} : '0;
      end
   end

   // column sum plus carry during product emission
   assign msum = {1'b0, col_in}
               + {{(mmp_pkg::ACC_BITS+1-mmp_pkg::CARRY_BITS){1'b0}}, carry_src};

   // low part and shifted high part of limb k for one fold step
   always_comb begin
      low = '0;
      if (ctrl.step < 5'd9) begin
         low = head;
      end else if (ctrl.step == 5'd9) begin
         low = head & mmp_pkg::TOP_MASK;
      end
      hi = '0;
      if (ctrl.step <= 5'd9) begin
         hi = {prod_ff[10][mmp_pkg::TOP_BITS-1:0], prod_ff[9][25:mmp_pkg::TOP_BITS]};
      end else if (ctrl.step == 5'd10) begin
         hi = {{mmp_pkg::TOP_BITS{1'b0}}, prod_ff[9][25:mmp_pkg::TOP_BITS]};
      end
   end

   assign fsum = {6'b0, low} + {3'b0, hi, 3'b0} + {6'b0, hi} + {26'b0, carry_src[5:0]};
   assign ssum = {1'b0, head} + {22'b0, carry_src[4:0]};

   // new limb entering the tail of the product chain
   always_comb begin
      case (ctrl.op)
         mmp_pkg::OP_MUL_EMIT: tail = msum[mmp_pkg::LIMB_BITS-1:0];
         mmp_pkg::OP_FOLD:     tail = fsum[mmp_pkg::LIMB_BITS-1:0];
         default:              tail = head;
      endcase
   end

   // product chain: shift toward the head, tail fed per phase
   always_comb begin
      for (int j = 0; j < mmp_pkg::PROD_LIMBS; j++) begin
         prod_in[j] = prod_ff[j];
      end
      if (ctrl.op == mmp_pkg::OP_MUL_EMIT || ctrl.op == mmp_pkg::OP_FOLD ||
          ctrl.op == mmp_pkg::OP_FINAL) begin
         for (int j = 0; j < mmp_pkg::PROD_LIMBS - 1; j++) begin
            prod_in[j] = prod_ff[j+1];
         end
         prod_in[mmp_pkg::PROD_LIMBS-1] = tail;
      end
   end

   // carry register per phase
   always_comb begin
      case (ctrl.op)
         mmp_pkg::OP_MUL_EMIT: carry_in = msum[mmp_pkg::ACC_BITS:mmp_pkg::LIMB_BITS];
         mmp_pkg::OP_FOLD:     carry_in = {25'b0, fsum[31:26]};
         mmp_pkg::OP_FINAL:    carry_in = {30'b0, ssum[mmp_pkg::LIMB_BITS]};
         default:              carry_in = carry_ff;
      endcase
   end

   // p-subtracted candidate chain, filled during the final pass
   always_comb begin
      for (int j = 0; j < mmp_pkg::NUM_LIMBS; j++) begin
         w_in[j] = w_ff[j];
      end
      if (ctrl.op == mmp_pkg::OP_FINAL) begin
         for (int j = 0; j < mmp_pkg::NUM_LIMBS - 1; j++) begin
            w_in[j] = w_ff[j+1];
         end
         w_in[mmp_pkg::NUM_LIMBS-1] = ssum[mmp_pkg::LIMB_BITS-1:0];
      end
   end

   // value + 9 reached 2^251 when bit 17 of the top candidate limb is set
   assign sel_w = w_ff[mmp_pkg::NUM_LIMBS-1][mmp_pkg::TOP_BITS];

   // residue chain: parallel load, then shift out one limb per item
   always_comb begin
      for (int j = 0; j < mmp_pkg::NUM_LIMBS; j++) begin
         res_in[j] = res_ff[j];
      end
      if (ctrl.op == mmp_pkg::OP_RES_LOAD) begin
         for (int j = 0; j < mmp_pkg::NUM_LIMBS; j++) begin
            res_in[j] = sel_w ? w_ff[j] : prod_ff[mmp_pkg::NUM_LIMBS + j];
         end
         if (sel_w) begin
            res_in[mmp_pkg::NUM_LIMBS-1] = w_ff[mmp_pkg::NUM_LIMBS-1] & mmp_pkg::TOP_MASK;
         end
      end else if (ctrl.res_shift) begin
         for (int j = 0; j < mmp_pkg::NUM_LIMBS - 1; j++) begin
            res_in[j] = res_ff[j+1];
         end
         res_in[mmp_pkg::NUM_LIMBS-1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      w_ff     <= w_in;
      res_ff   <= res_in;
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in;
      end
   end

   assign res_head = res_ff[0];

endmodule

/* rtl/modmul_p251_minus_9.sv */
// top level: limb loading, sequencer, multiply row and result output
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata: a_limb, b_limb; tlast: last_in
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: result_limb; tlast: last_out
//
// one limb pair loads per cycle while in the load state; the item with tlast starts the operation
// operation: multiply and carry, three folding rounds, final subtract and residue load,
// in that order, each phase stepping through the serial limb chain
// result limbs drain one per cycle while rsp_tready is high; loading of the next operand overlaps it
// reset clears all control state and the operand cells
module modmul_p251_minus_9 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // a_limb[25:0], b_limb[51:26], zero pad [55:52]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_limb[25:0], zero pad [31:26]
   output logic        rsp_tlast
);

   mmp_pkg::state_type state_ff, state_in;
   mmp_pkg::step_type  step_ff, step_in;
   logic [mmp_pkg::RND_BITS-1:0] round_ff, round_in;
   mmp_pkg::cnt_type   count_ff, count_in;
   mmp_pkg::cnt_type   out_cnt_ff, out_cnt_in;
   mmp_pkg::limb_type  a_ff [mmp_pkg::NUM_LIMBS];
   mmp_pkg::limb_type  a_in [mmp_pkg::NUM_LIMBS];
   mmp_pkg::acc_type   acc  [mmp_pkg::NUM_LIMBS];
   mmp_pkg::acc_type   acc_right [mmp_pkg::NUM_LIMBS];
   mmp_pkg::ctrl_type  ctrl;
   mmp_pkg::limb_type  res_head;
   logic req_acc, rsp_acc, mac_en, b_clr;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mmp_pkg::ST_LOAD:  if (req_acc && req_tlast) state_in = mmp_pkg::ST_MUL;
         mmp_pkg::ST_MUL:   if (step_ff == 5'd20) state_in = mmp_pkg::ST_FOLD;
         mmp_pkg::ST_FOLD: begin
            if (step_ff == 5'd19 && round_ff == 2'(mmp_pkg::FOLD_ROUNDS - 1)) begin
               state_in = mmp_pkg::ST_FINAL;
            end
         end
         mmp_pkg::ST_FINAL: if (step_ff == 5'd9) state_in = mmp_pkg::ST_RES;
         mmp_pkg::ST_RES:   if (out_cnt_ff == '0) state_in = mmp_pkg::ST_LOAD;
         default:           state_in = mmp_pkg::ST_LOAD;
      endcase
   end

   // step and round counters
   always_comb begin
      step_in  = step_ff;
      round_in = round_ff;
      case (state_ff)
         mmp_pkg::ST_MUL: step_in = (step_ff == 5'd20) ? '0 : step_ff + 5'd1;
         mmp_pkg::ST_FOLD: begin
            if (step_ff == 5'd19) begin
               step_in  = '0;
               round_in = (round_ff == 2'(mmp_pkg::FOLD_ROUNDS - 1)) ? '0 : round_ff + 2'd1;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         mmp_pkg::ST_FINAL: step_in = (step_ff == 5'd9) ? '0 : step_ff + 5'd1;
         default: begin
            step_in  = '0;
            round_in = '0;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready     = (state_ff == mmp_pkg::ST_LOAD);
      mac_en         = (state_ff == mmp_pkg::ST_MUL);
      b_clr          = (state_ff == mmp_pkg::ST_MUL) && (step_ff == 5'd20);
      ctrl.step      = step_ff;
      ctrl.res_shift = rsp_acc;
      ctrl.first     = 1'b0;
      ctrl.op        = mmp_pkg::OP_IDLE;
      case (state_ff)
         mmp_pkg::ST_MUL: begin
            if (step_ff != '0) ctrl.op = mmp_pkg::OP_MUL_EMIT;
            ctrl.first = (step_ff == 5'd1);
         end
         mmp_pkg::ST_FOLD: begin
            ctrl.op    = mmp_pkg::OP_FOLD;
            ctrl.first = (step_ff == '0);
         end
         mmp_pkg::ST_FINAL: begin
            ctrl.op    = mmp_pkg::OP_FINAL;
            ctrl.first = (step_ff == '0);
         end
         mmp_pkg::ST_RES: if (out_cnt_ff == '0) ctrl.op = mmp_pkg::OP_RES_LOAD;
         default: ctrl.op = mmp_pkg::OP_IDLE;
      endcase
   end

   // a limbs: written at the fill count, shifted out during multiply
   always_comb begin
      for (int j = 0; j < mmp_pkg::NUM_LIMBS; j++) begin
         a_in[j] = a_ff[j];
      end
      count_in = count_ff;
      if (state_ff == mmp_pkg::ST_MUL) begin
         for (int j = 0; j < mmp_pkg::NUM_LIMBS - 1; j++) begin
            a_in[j] = a_ff[j+1];
         end
         a_in[mmp_pkg::NUM_LIMBS-1] = '0;
         count_in = '0;
      end else if (req_acc && count_ff < 4'(mmp_pkg::NUM_LIMBS)) begin
         a_in[count_ff] = req_tdata[25:0];
         count_in       = count_ff + 4'd1;
      end
   end

   // result counter
   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (ctrl.op == mmp_pkg::OP_RES_LOAD) begin
         out_cnt_in = 4'(mmp_pkg::NUM_LIMBS);
      end else if (rsp_acc) begin
         out_cnt_in = out_cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mmp_pkg::ST_LOAD;
         step_ff    <= '0;
         round_ff   <= '0;
         count_ff   <= '0;
         out_cnt_ff <= '0;
         for (int j = 0; j < mmp_pkg::NUM_LIMBS; j++) begin
            a_ff[j] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         round_ff   <= round_in;
         count_ff   <= count_in;
         out_cnt_ff <= out_cnt_in;
         a_ff       <= a_in;
      end
   end

   // multiply row: sums move one cell toward cell 0 every step
   for (genvar j = 0; j < mmp_pkg::NUM_LIMBS; j++) begin : g_mac
      if (j == mmp_pkg::NUM_LIMBS - 1) begin : g_end
         assign acc_right[j] = '0;
      end else begin : g_mid
         assign acc_right[j] = acc[j+1];
      end
      mmp_mac_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (mac_en),
         .b_wr      (req_acc && count_ff == 4'(j)),
         .b_clr     (b_clr),
         .b_val     (req_tdata[51:26]),
         .a_val     (a_ff[0]),
         .acc_right (acc_right[j]),
         .acc       (acc[j])
      );
   end

   mmp_reduce u_reduce (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .col_in   (acc[0]),
      .res_head (res_head)
   );

   assign rsp_tvalid = (out_cnt_ff != '0);
   assign rsp_tlast  = (out_cnt_ff == 4'd1);
   assign rsp_tdata  = {6'b0, res_head};

   // at most ten result limbs pending
   a_out_cnt: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= 4'(mmp_pkg::NUM_LIMBS))
      else $error("result count above limb count");

   // a final item starts the multiply
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tlast) |=> state_ff == mmp_pkg::ST_MUL)
      else $error("last item did not start the operation");

   // residue load fills the output
   a_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mmp_pkg::ST_RES && out_cnt_ff == '0) |=>
      (out_cnt_ff == 4'(mmp_pkg::NUM_LIMBS) && state_ff == mmp_pkg::ST_LOAD))
      else $error("residue not loaded");

endmodule

/* bench/modmul_p251_minus_9_test.sv */
// testbench for the 2^251-9 modular multiplier: directed and random operands
module modmul_p251_minus_9_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // a_limb[25:0], b_limb[51:26], zero pad [55:52]
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // result_limb[25:0], zero pad [31:26]
   logic        rsp_tlast;

   modmul_p251_minus_9 u_top (.*);

   // operand state of the predictor
   logic [25:0] a_limbs [mmp_pkg::NUM_LIMBS];
   logic [25:0] b_limbs [mmp_pkg::NUM_LIMBS];
   int          loaded;
   logic [26:0] residue_q [$];   // {last_out, result_limb}

   int errors;
   int cycles;
   int send_idle;     // percent of cycles the sender idles
   int recv_idle;     // percent of cycles the receiver stalls
   int hold_cycles;   // long receiver hold-off
   int result_count;

   // p = 2^251 - 9
   localparam logic [519:0] MODULUS = (520'd1 << 251) - 520'd9;

   // product of the loaded operands reduced mod p, pushed as ten limbs
   function automatic void predict_residue();
      logic [519:0] av, bv, pv;
      av = '0;
      bv = '0;
      for (int i = mmp_pkg::NUM_LIMBS - 1; i >= 0; i--) begin
         av = (av << mmp_pkg::LIMB_BITS) | {494'd0, a_limbs[i]};
         bv = (bv << mmp_pkg::LIMB_BITS) | {494'd0, b_limbs[i]};
      end
      pv = (av * bv) % MODULUS;
      for (int k = 0; k < mmp_pkg::NUM_LIMBS; k++) begin
         residue_q.push_back({k == mmp_pkg::NUM_LIMBS - 1, pv[25:0]});
         pv = pv >> mmp_pkg::LIMB_BITS;
      end
   endfunction

   task automatic report(input string what, input logic [26:0] got, input logic [26:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // cycle counter and run limit
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT_CYCLES) begin
            $display("timeout");
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // receiver: random stalls plus a long hold-off on request
   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 0;
         end else
            rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (residue_q.size() == 0)
            report("unexpected item", {rsp_tlast, rsp_tdata[25:0]}, '0);
         else begin
            logic [26:0] want;
            want = residue_q.pop_front();
            if (rsp_tdata[25:0] !== want[25:0])
               report("result_limb", {1'b0, rsp_tdata[25:0]}, {1'b0, want[25:0]});
            if (rsp_tlast !== want[26])
               report("last_out", {26'd0, rsp_tlast}, {26'd0, want[26]});
            if (rsp_tdata[31:26] !== 6'd0)
               report("pad", {21'd0, rsp_tdata[31:26]}, '0);
            result_count++;
         end
      end
   end

   // offer one item and wait for it to be taken; predict on acceptance
   task automatic send_item(input logic [25:0] a, input logic [25:0] b, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {4'd0, b, a};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (loaded < mmp_pkg::NUM_LIMBS) begin
         a_limbs[loaded] = a;
         b_limbs[loaded] = b;
         loaded++;
      end
      if (last) begin
         predict_residue();
         loaded = 0;
         foreach (a_limbs[i]) begin
            a_limbs[i] = '0;
            b_limbs[i] = '0;
         end
      end
      @(negedge clock);
   endtask

   task automatic send_operands(input logic [25:0] a [], input logic [25:0] b [], input int n);
      for (int i = 0; i < n; i++)
         send_item(a[i], b[i], i == n - 1);
   endtask

   task automatic test_extremes();
      logic [25:0] a [], b [];
      a = new[10];
      b = new[10];
      foreach (a[i]) begin a[i] = '0; b[i] = '0; end
      send_operands(a, b, 10);                         // zero
      foreach (a[i]) begin a[i] = 26'h3FFFFFF; b[i] = 26'h3FFFFFF; end
      send_operands(a, b, 10);                         // operands above p
      a[0] = 26'd1; b[0] = 26'h2AAAAAA;
      send_operands(a, b, 1);                          // short operand of one limb
   endtask

   task automatic test_boundaries();
      logic [25:0] a [], b [];
      a = new[10];
      b = new[10];
      // a = p, b = 1: result zero
      foreach (a[i]) begin a[i] = 26'h3FFFFFF; b[i] = '0; end
      a[0] = 26'h3FFFFF7; a[9] = 26'h1FFFF; b[0] = 26'd1;
      send_operands(a, b, 10);
      // a = p - 1, b = p - 1
      a[0] = 26'h3FFFFF6;
      b = new[10](a);
      send_operands(a, b, 10);
      // a = 2^251, b = 1: wraps to nine
      foreach (a[i]) begin a[i] = '0; b[i] = '0; end
      a[9] = 26'h20000; b[0] = 26'd1;
      send_operands(a, b, 10);
   endtask

   task automatic test_too_many_limbs();
      for (int i = 0; i < 13; i++)
         send_item(26'($urandom), 26'($urandom), i == 12);
   endtask

   task automatic test_random(input int items);
      int sent, n;
      sent = 0;
      while (sent < items) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(1, 13) : 10;
         for (int i = 0; i < n; i++) begin
            logic [25:0] a, b;
            case ($urandom_range(5))
               0: begin a = 26'h3FFFFFF; b = 26'($urandom); end
               1: begin a = 26'($urandom); b = 26'h3FFFFFF; end
               2: begin a = '0; b = 26'($urandom); end
               default: begin a = 26'($urandom); b = 26'($urandom); end
            endcase
            send_item(a, b, i == n - 1);
         end
         sent += n;
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 600;
      for (int i = 0; i < 40; i++)
         send_item(26'($urandom), 26'($urandom), (i % 10) == 9);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (residue_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      errors = 0;
      result_count = 0;
      hold_cycles = 0;
      loaded = 0;
      foreach (a_limbs[i]) begin a_limbs[i] = '0; b_limbs[i] = '0; end
      send_idle = 12;
      recv_idle = 81;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tlast = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_extremes();
      test_boundaries();
      test_too_many_limbs();
      test_random(140);
      send_idle = 81;
      recv_idle = 12;
      test_random(130);
      send_idle = 0;
      recv_idle = 0;
      test_backpressure();
      test_random(60);
      drain();

      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
